>>> hdl/stft_pkg.sv
// Package for the sparse triplet fast transpose block.
// Holds the controller states, beat and term layouts, register indexes and defaults.
// No dependencies.
`timescale 1ns / 1ps

package stft_pkg;

  localparam int MAX_TERMS_DEF = 63;
  localparam int MAX_DIM_DEF   = 128;

  localparam int ROW_W   = 7;
  localparam int COL_W   = 7;
  localparam int VAL_W   = 32;
  localparam int DIM_W   = 8;
  localparam int CFG_W   = 8;
  localparam int TERM_W  = ROW_W + COL_W + VAL_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_W-1:0] ROWS_RESET = 8'd128;
  localparam logic [CFG_W-1:0] COLS_RESET = 8'd128;

  // register indexes on the configuration port
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_LOAD,
    ST_INC,
    ST_PRE,
    ST_SC_RT,
    ST_SC_RS,
    ST_SC_WR,
    ST_EM_HDR,
    ST_EM_RD,
    ST_EM_OUT
  } stft_state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
  } stft_term_t;

  typedef struct packed {
    logic                    is_header;
    logic [DIM_W-1:0]        row;
    logic [DIM_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } stft_beat_t;

endpackage

>>> hdl/stft_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read data holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps

module stft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/stft_obuf.sv
// Output register of the transpose block: holds one result beat for the master side.
// Depends on stft_pkg.
`timescale 1ns / 1ps

module stft_obuf
  import stft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  stft_beat_t load_beat,
  output logic       load_ok,
  output logic       out_tvalid,
  input  logic       out_tready,
  output stft_beat_t out_beat
);

  logic       valid_r;
  logic       valid_nxt;
  stft_beat_t beat_r;

  // free when empty or when the held beat leaves this cycle
  assign load_ok = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load && load_ok) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load && load_ok) begin
      beat_r <= load_beat;
    end
  end

  assign out_tvalid = valid_r;
  assign out_beat   = beat_r;

endmodule

>>> hdl/sparse_triplet_fast_transpose.sv
// Top level of the sparse triplet fast transpose: controller, four RAMs, output register.
// Depends on stft_pkg, stft_ram and stft_obuf.
//
//  channel | dir | tdata (low bit up)              | tuser     | tlast
//  in_     | in  | term_row, term_col, term_value  | has_term  | set_end
//  out_    | out | out_row, out_col, out_value     | is_header | run_end
//  cfg_    | in  | index 0 num_rows, 1 num_cols    | -         | -
//
// A stored term beat is accepted and written to the term store, then the column count gets a
// read-modify-write; a dropped or bare beat is only accepted. After the end beat: prefix sum
// over the count RAM, scatter of each term (term read, start read, ordered write), then the
// header and each term beat out of the ordered RAM (read, then output register load).
// After reset a clearing pass zeroes the count RAM; no input beat is taken meanwhile.
// A stalled output holds the controller.
`timescale 1ns / 1ps

module sparse_triplet_fast_transpose
  import stft_pkg::*;
#(
  parameter int MAX_TERMS = MAX_TERMS_DEF,
  parameter int MAX_DIM   = MAX_DIM_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // term_row[6:0], term_col[13:7], term_value[45:14]
  input  logic                   in_tuser,   // has_term
  input  logic                   in_tlast,   // set_end
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out_row[7:0], out_col[15:8], out_value[47:16]
  output logic                   out_tuser,  // is_header
  output logic                   out_tlast,  // run_end
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int TERM_AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W   = $clog2(MAX_TERMS + 1);
  localparam int DIM_AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int IDX_W   = $clog2(MAX_DIM + 1);

  // configuration registers
  logic [CFG_W-1:0] num_rows_r;
  logic [CFG_W-1:0] num_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= ROWS_RESET;
      num_cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_ROWS) begin
        num_rows_r <= cfg_data;
      end
      if (cfg_index == REG_NUM_COLS) begin
        num_cols_r <= cfg_data;
      end
    end
  end

  // RAM ports
  logic              ts_we, ts_re;
  logic [TERM_AW-1:0] ts_wa, ts_ra;
  stft_term_t        ts_wd, ts_rd;
  logic              od_we, od_re;
  logic [TERM_AW-1:0] od_wa, od_ra;
  stft_term_t        od_wd, od_rd;
  logic              cn_we, cn_re;
  logic [DIM_AW-1:0] cn_wa, cn_ra;
  logic [CNT_W-1:0]  cn_wd, cn_rd;
  logic              sp_we, sp_re;
  logic [DIM_AW-1:0] sp_wa, sp_ra;
  logic [CNT_W-1:0]  sp_wd, sp_rd;

  stft_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_term_ram (
    .clk(clk), .wr_en(ts_we), .wr_addr(ts_wa), .wr_data(ts_wd),
    .rd_en(ts_re), .rd_addr(ts_ra), .rd_data(ts_rd)
  );

  stft_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_order_ram (
    .clk(clk), .wr_en(od_we), .wr_addr(od_wa), .wr_data(od_wd),
    .rd_en(od_re), .rd_addr(od_ra), .rd_data(od_rd)
  );

  stft_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DIM)) u_count_ram (
    .clk(clk), .wr_en(cn_we), .wr_addr(cn_wa), .wr_data(cn_wd),
    .rd_en(cn_re), .rd_addr(cn_ra), .rd_data(cn_rd)
  );

  stft_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DIM)) u_start_ram (
    .clk(clk), .wr_en(sp_we), .wr_addr(sp_wa), .wr_data(sp_wd),
    .rd_en(sp_re), .rd_addr(sp_ra), .rd_data(sp_rd)
  );

  // output register
  logic       ob_load, ob_ok;
  stft_beat_t ob_beat, out_beat;

  stft_obuf u_obuf (
    .clk(clk), .rst_n(rst_n), .load(ob_load), .load_beat(ob_beat), .load_ok(ob_ok),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_beat(out_beat)
  );

  assign out_tdata = {out_beat.value, out_beat.col, out_beat.row};
  assign out_tuser = out_beat.is_header;
  assign out_tlast = out_beat.last;

  // controller
  stft_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [DIM_AW-1:0] col_r, col_nxt;
  logic              end_r, end_nxt;

  stft_term_t        in_term;
  logic              in_acc;
  logic              term_ok;
  logic [DIM_AW-1:0] prev_addr;
  logic [DIM_AW-1:0] sc_col;

  assign in_term   = in_tdata[TERM_W-1:0];
  assign in_acc    = in_tvalid && in_tready;
  assign prev_addr = DIM_AW'(idx_r - IDX_W'(1));
  assign sc_col    = DIM_AW'(ts_rd.col);

  always_comb begin
    term_ok = in_tuser && (held_r < CNT_W'(MAX_TERMS)) &&
              ({1'b0, in_term.row} < num_rows_r) &&
              ({1'b0, in_term.col} < num_cols_r) &&
              (9'(in_term.col) < 9'(MAX_DIM));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      held_r  <= '0;
      ptr_r   <= '0;
      pos_r   <= '0;
      idx_r   <= '0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      ptr_r   <= ptr_nxt;
      pos_r   <= pos_nxt;
      idx_r   <= idx_nxt;
      end_r   <= end_nxt;
    end
    col_r <= col_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    ptr_nxt   = ptr_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    col_nxt   = col_r;
    end_nxt   = end_r;
    in_tready = 1'b0;
    ts_we = 1'b0; ts_wa = TERM_AW'(held_r); ts_wd = in_term;
    ts_re = 1'b0; ts_ra = TERM_AW'(ptr_r);
    od_we = 1'b0; od_wa = TERM_AW'(sp_rd); od_wd = ts_rd;
    od_re = 1'b0; od_ra = TERM_AW'(ptr_r);
    cn_we = 1'b0; cn_wa = col_r; cn_wd = cn_rd + CNT_W'(1);
    cn_re = 1'b0; cn_ra = DIM_AW'(in_term.col);
    sp_we = 1'b0; sp_wa = sc_col; sp_wd = sp_rd + CNT_W'(1);
    sp_re = 1'b0; sp_ra = sc_col;
    ob_load = 1'b0;
    ob_beat.is_header = 1'b0;
    ob_beat.row   = DIM_W'(od_rd.col);
    ob_beat.col   = DIM_W'(od_rd.row);
    ob_beat.value = od_rd.value;
    ob_beat.last  = (ptr_r + CNT_W'(1) == held_r);

    case (state_r)
      ST_CLR: begin
        // zero the count RAM after reset
        cn_we = 1'b1;
        cn_wa = DIM_AW'(idx_r);
        cn_wd = '0;
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(MAX_DIM - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_acc) begin
          end_nxt = in_tlast;
          idx_nxt = '0;
          pos_nxt = '0;
          if (term_ok) begin
            ts_we     = 1'b1;
            cn_re     = 1'b1;
            col_nxt   = DIM_AW'(in_term.col);
            held_nxt  = held_r + CNT_W'(1);
            state_nxt = ST_INC;
          end else if (in_tlast) begin
            state_nxt = ST_PRE;
          end
        end
      end
      ST_INC: begin
        cn_we = 1'b1;
        state_nxt = end_r ? ST_PRE : ST_LOAD;
      end
      ST_PRE: begin
        // read count of column idx, write start of column idx-1 and clear its count
        cn_re = (idx_r < IDX_W'(MAX_DIM));
        cn_ra = DIM_AW'(idx_r);
        if (idx_r != '0) begin
          sp_we   = 1'b1;
          sp_wa   = prev_addr;
          sp_wd   = pos_r;
          cn_we   = 1'b1;
          cn_wa   = prev_addr;
          cn_wd   = '0;
          pos_nxt = pos_r + cn_rd;
        end
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(MAX_DIM)) begin
          idx_nxt   = '0;
          ptr_nxt   = '0;
          state_nxt = ST_SC_RT;
        end
      end
      ST_SC_RT: begin
        if (ptr_r == held_r) begin
          state_nxt = ST_EM_HDR;
        end else begin
          ts_re     = 1'b1;
          state_nxt = ST_SC_RS;
        end
      end
      ST_SC_RS: begin
        sp_re     = 1'b1;
        state_nxt = ST_SC_WR;
      end
      ST_SC_WR: begin
        od_we     = (sp_rd < CNT_W'(MAX_TERMS));
        sp_we     = 1'b1;
        ptr_nxt   = ptr_r + CNT_W'(1);
        state_nxt = ST_SC_RT;
      end
      ST_EM_HDR: begin
        ob_load = 1'b1;
        ob_beat.is_header = 1'b1;
        ob_beat.row   = num_cols_r;
        ob_beat.col   = num_rows_r;
        ob_beat.value = VAL_W'(held_r);
        ob_beat.last  = (held_r == '0);
        if (ob_ok) begin
          ptr_nxt   = '0;
          state_nxt = ST_EM_RD;
        end
      end
      ST_EM_RD: begin
        if (ptr_r == held_r) begin
          // matrix done: drop held terms and wait for the next one
          held_nxt  = '0;
          end_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          od_re     = 1'b1;
          state_nxt = ST_EM_OUT;
        end
      end
      ST_EM_OUT: begin
        ob_load = 1'b1;
        if (ob_ok) begin
          ptr_nxt   = ptr_r + CNT_W'(1);
          state_nxt = ST_EM_RD;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

endmodule

>>> tb/sparse_triplet_fast_transpose_test.sv
// Testbench for sparse_triplet_fast_transpose: drives triplet beats and size registers and
// predicts the header and the column-major transposed terms in a scoreboard class.
// Depends on stft_pkg and the block's RTL.
`timescale 1ns / 1ps

module sparse_triplet_fast_transpose_test;
  import stft_pkg::*;

  localparam int LONG_HOLD     = 500;
  localparam int SETTLE_CYCLES = 300;
  localparam int PHASE_BEATS   = 14;

  class transpose_scoreboard;
    logic [CFG_W-1:0] num_rows;
    logic [CFG_W-1:0] num_cols;
    stft_term_t       held_terms[$];
    stft_beat_t       expected_beats[$];
    int               mismatches;

    function new();
      num_rows   = ROWS_RESET;
      num_cols   = COLS_RESET;
      mismatches = 0;
    endfunction

    function void set_size(logic idx, logic [CFG_W-1:0] val);
      if (idx == REG_NUM_ROWS) begin
        num_rows = val;
      end else begin
        num_cols = val;
      end
    endfunction

    // Take the term if it fits, and on the end marker queue the whole transposed matrix.
    function void collect_term(logic has_term, stft_term_t term, logic set_end);
      stft_beat_t beat;
      int         total;
      int         sent;
      if (has_term && held_terms.size() < MAX_TERMS_DEF &&
          {1'b0, term.row} < num_rows && {1'b0, term.col} < num_cols) begin
        held_terms.push_back(term);
      end
      if (!set_end) return;
      total          = held_terms.size();
      beat.is_header = 1'b1;
      beat.row       = num_cols;
      beat.col       = num_rows;
      beat.value     = total;
      beat.last      = (total == 0);
      expected_beats.push_back(beat);
      sent = 0;
      // stable bucket order: ascending column, arrival order within a column
      for (int c = 0; c < MAX_DIM_DEF; c++) begin
        foreach (held_terms[i]) begin
          if (held_terms[i].col == c) begin
            sent++;
            beat.is_header = 1'b0;
            beat.row       = {1'b0, held_terms[i].col};
            beat.col       = {1'b0, held_terms[i].row};
            beat.value     = held_terms[i].value;
            beat.last      = (sent == total);
            expected_beats.push_back(beat);
          end
        end
      end
      held_terms.delete();
    endfunction

    function void compare_field(string name, longint unsigned exp_val,
                                longint unsigned got_val);
      if (exp_val != got_val) begin
        $error("%s: expected %0h, got %0h", name, exp_val, got_val);
        mismatches++;
      end
    endfunction

    function void check_transposed(logic is_header, logic [DIM_W-1:0] row,
                                   logic [DIM_W-1:0] col, logic [VAL_W-1:0] value,
                                   logic last);
      stft_beat_t exp_beat;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: row %0d col %0d value %0h",
               row, col, value);
        mismatches++;
        return;
      end
      exp_beat = expected_beats.pop_front();
      compare_field("is_header", exp_beat.is_header, is_header);
      compare_field("out_row", exp_beat.row, row);
      compare_field("out_col", exp_beat.col, col);
      compare_field("out_value", $unsigned(exp_beat.value), value);
      compare_field("run_end", exp_beat.last, last);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = REG_NUM_ROWS;
  logic [CFG_W-1:0]       cfg_data = '0;

  transpose_scoreboard sb = new();

  logic             hold_request = 1'b0;
  logic             hold_active = 1'b0;
  logic             sender_burst = 1'b0;
  logic [CFG_W-1:0] cur_rows = ROWS_RESET;
  logic [CFG_W-1:0] cur_cols = COLS_RESET;

  sparse_triplet_fast_transpose u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // mostly short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ROW_W-1:0] pick_index(logic [CFG_W-1:0] limit);
    int hi;
    if (limit == 0 || $urandom_range(0, 99) < 15) return ROW_W'($urandom_range(0, 127));
    hi = (limit > 128) ? 127 : limit - 1;
    return ROW_W'($urandom_range(0, hi));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_beat(logic has_term, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [VAL_W-1:0] value, logic set_end);
    stft_term_t term;
    int         gap;
    term.row   = row;
    term.col   = col;
    term.value = value;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, value, col, row};
    in_tuser  <= has_term;
    in_tlast  <= set_end;
    do @(posedge clk); while (!in_tready);
    sb.collect_term(has_term, term, set_end);
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_size(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_size(idx, val);
    if (idx == REG_NUM_ROWS) begin
      cur_rows = val;
    end else begin
      cur_cols = val;
    end
  endtask

  // Drop valid, wait for every expected beat, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sizes(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols);
    drain();
    write_size(REG_NUM_ROWS, rows);
    write_size(REG_NUM_COLS, cols);
  endtask

  // One matrix with random content; noise beats are not counted.
  task automatic send_matrix(int n_terms, inout int counted);
    logic end_on_term;
    end_on_term = (n_terms > 0) && $urandom_range(0, 1);
    for (int k = 0; k < n_terms; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(1'b0, ROW_W'($urandom_range(0, 127)), COL_W'($urandom_range(0, 127)),
                  $urandom(), 1'b0);
      end
      send_beat(1'b1, pick_index(cur_rows), pick_index(cur_cols), pick_value(),
                end_on_term && (k == n_terms - 1));
      counted++;
    end
    if (!end_on_term) begin
      send_beat(1'b0, ROW_W'($urandom_range(0, 127)), COL_W'($urandom_range(0, 127)),
                $urandom(), 1'b1);
      counted++;
    end
  endtask

  function automatic int pick_matrix_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 12);
    if (r < 90) return $urandom_range(13, 40);
    return $urandom_range(55, 70);
  endfunction

  // receiver: random tready with free-running stretches and one long hold on request
  initial begin
    int run;
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_active = 1'b0;
      end
      if ($urandom_range(0, 4) == 0) begin
        run = $urandom_range(100, 200);
        gap = 0;
      end else begin
        run = $urandom_range(1, 30);
        gap = pick_gap();
      end
      @(negedge clk);
      out_tready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      if (gap > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_transposed(out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[47:16],
                          out_tlast);
    end
  end

  initial begin
    logic [CFG_W-1:0] rows_list[7];
    logic [CFG_W-1:0] cols_list[7];
    int               counted;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_size(REG_NUM_ROWS, 8'd128);
    write_size(REG_NUM_COLS, 8'd128);

    // extremes, bare end, empty beat, ties within a column, term and end together
    send_beat(1'b0, 7'd0, 7'd0, 32'h0, 1'b1);
    send_beat(1'b0, 7'd127, 7'd127, 32'hffff_ffff, 1'b0);
    send_beat(1'b1, 7'd0, 7'd0, 32'h8000_0000, 1'b0);
    send_beat(1'b1, 7'd127, 7'd127, 32'h7fff_ffff, 1'b0);
    send_beat(1'b1, 7'd5, 7'd3, 32'hffff_ffff, 1'b0);
    send_beat(1'b1, 7'd9, 7'd3, 32'h0, 1'b0);
    send_beat(1'b1, 7'd2, 7'd0, 32'h1, 1'b0);
    send_beat(1'b1, 7'd64, 7'd3, 32'h5555_aaaa, 1'b1);

    // smallest size: out-of-size rows and columns are dropped
    set_sizes(8'd1, 8'd1);
    send_beat(1'b1, 7'd0, 7'd0, 32'h1234_5678, 1'b0);
    send_beat(1'b1, 7'd1, 7'd0, 32'h1, 1'b0);
    send_beat(1'b1, 7'd0, 7'd1, 32'h2, 1'b0);
    send_beat(1'b1, 7'd127, 7'd127, 32'h3, 1'b1);

    // zero rows: every term dropped, header only
    set_sizes(8'd0, 8'd5);
    send_beat(1'b1, 7'd0, 7'd0, 32'hdead_beef, 1'b0);
    send_beat(1'b0, 7'd0, 7'd0, 32'h0, 1'b1);

    rows_list = '{8'd128, 8'd1, 8'd128, 8'd255, 8'd16, 8'd0, 8'd0};
    cols_list = '{8'd128, 8'd128, 8'd1, 8'd200, 8'd8, 8'd0, 8'd0};
    for (int p = 5; p < 7; p++) begin
      rows_list[p] = CFG_W'($urandom_range(1, 128));
      cols_list[p] = CFG_W'($urandom_range(1, 128));
    end

    for (int p = 0; p < 7; p++) begin
      set_sizes(rows_list[p], cols_list[p]);
      counted = 0;
      if (p == 0) begin
        // overfill the store, then hold the output off while matrices queue up
        sender_burst = 1'b0;
        send_matrix(70, counted);
        // drop valid so the last beat is not offered again while the hold starts
        @(negedge clk);
        in_tvalid <= 1'b0;
        hold_request = 1'b1;
        wait (hold_active);
        sender_burst = 1'b1;
        for (int m = 0; m < 4; m++) send_matrix($urandom_range(3, 10), counted);
      end
      while (counted < PHASE_BEATS) begin
        sender_burst = ($urandom_range(0, 3) == 0);
        send_matrix(pick_matrix_size(), counted);
      end
      sender_burst = 1'b0;
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #1_600_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> sparse_triplet_fast_transpose.f
hdl/stft_pkg.sv
hdl/stft_ram.sv
hdl/stft_obuf.sv
hdl/sparse_triplet_fast_transpose.sv
tb/sparse_triplet_fast_transpose_test.sv
